/* hw/rtl/dsp_pkg.sv */
package dsp_pkg;

  // Default mantissa width; the block supports 64 to 128 bits.
  localparam int MANTISSA_BITS_DEF = 128;

  // Fixed field widths of the stream interface.
  localparam int CHAR_W     = 8;
  localparam int OUT_MANT_W = 128;
  localparam int SCALE_W    = 16;
  localparam int STATUS_W   = 3;

  localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

  // Character codes the parser looks for.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef logic [STATUS_W-1:0] status_t;

  // Status codes returned with each result.
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_EMPTY     = 3'd1;
  localparam status_t ST_POINTS    = 3'd2;
  localparam status_t ST_INVALID   = 3'd3;
  localparam status_t ST_NO_DIGITS = 3'd4;

  // Parser flags handed from the accumulator to the result stage.
  typedef struct packed {
    logic                lead;
    logic                negative;
    logic                seen_digit;
    status_t             err;
    logic [SCALE_W-1:0]  frac_count;
  } dsp_summary_t;

endpackage

/* hw/rtl/decimal_string_parser_core.sv */
// The end request of a string passes from the input register into the result register, where its result becomes valid,
// provided the result register is free; otherwise the end request waits in the input register.
// Throughput: one request (a character or an end mark) per cycle while no end request waits, set by the single
// registered pass of the character decoder and the times-ten shift-add on the mantissa.
// Reset (rst_ni low, asynchronous) empties both registers and returns the parser to
// leading whitespace with a zero mantissa, zero scale and no latched error.
module decimal_string_parser_core import dsp_pkg::*; #(
  parameter int MANTISSA_BITS = MANTISSA_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream: one character request per transfer.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] character
  input  logic                s_axis_tlast,   // end_of_string; tdata is ignored
  // Result stream: one result per string.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [143:0]        m_axis_tdata,   // [63:0] mantissa_low, [127:64] mantissa_high,
                                              // [143:128] scale
  output logic [2:0]          m_axis_tuser    // [2:0] status
);

  logic                     in_valid;
  logic [CHAR_W-1:0]        in_char;
  logic                     in_eos;
  logic                     advance;
  logic                     out_free;
  dsp_summary_t             summary;
  logic [MANTISSA_BITS-1:0] mant;
  logic [OUT_MANT_W-1:0]    res_mant;
  logic [SCALE_W-1:0]       res_scale;
  status_t                  res_status;

  // The input register holds one request. A character request always moves on; an end
  // request moves on only when the result register is empty or being drained, so a
  // waiting result never blocks the characters of the following string.
  assign advance = in_valid && (!in_eos || out_free);

  dsp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_char_i  (s_axis_tdata),
    .s_eos_i   (s_axis_tlast),
    .advance_i (advance),
    .valid_o   (in_valid),
    .char_o    (in_char),
    .eos_o     (in_eos)
  );

  // The accumulator decodes one character per cycle while the input register advances: sign, point, digits, whitespace
  // and the first error, with the mantissa updated as ten times itself plus the digit.
  dsp_accum #(
    .MANTISSA_BITS (MANTISSA_BITS)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .char_i    (in_char),
    .eos_i     (in_eos),
    .summary_o (summary),
    .mant_o    (mant)
  );

  // On an end request the result stage reads the accumulated state before it is
  // cleared, applies the sign, sign-extends to 128 bits and resolves the status.
  dsp_result #(
    .MANTISSA_BITS (MANTISSA_BITS)
  ) u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && in_eos),
    .summary_i  (summary),
    .mant_i     (mant),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_mant_o   (res_mant),
    .m_scale_o  (res_scale),
    .m_status_o (res_status),
    .free_o     (out_free)
  );

  assign m_axis_tdata = {res_scale, res_mant};
  assign m_axis_tuser = res_status;

endmodule

/* hw/rtl/dsp_in_reg.sv */
module dsp_in_reg import dsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [CHAR_W-1:0] s_char_i,
  input  logic              s_eos_i,
  input  logic              advance_i,
  output logic              valid_o,
  output logic [CHAR_W-1:0] char_o,
  output logic              eos_o
);

  logic              valid_q, valid_d;
  logic [CHAR_W-1:0] char_q;
  logic              eos_q;

  // The register may take a new request when it is empty or drains this cycle.
  assign s_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      char_q <= s_char_i;
      eos_q  <= s_eos_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign eos_o   = eos_q;

endmodule

/* hw/rtl/dsp_accum.sv */
module dsp_accum import dsp_pkg::*; #(
  parameter int MANTISSA_BITS = MANTISSA_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [CHAR_W-1:0]        char_i,
  input  logic                     eos_i,
  output dsp_summary_t             summary_o,
  output logic [MANTISSA_BITS-1:0] mant_o
);

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [1:0]               phase_q, phase_d;
  logic                     neg_q, neg_d;
  logic                     frac_q, frac_d;
  logic                     seen_q, seen_d;
  logic [MANTISSA_BITS-1:0] mant_q, mant_d;
  logic [SCALE_W-1:0]       count_q, count_d;
  status_t                  err_q, err_d;

  logic                     is_space, is_digit, do_body;
  logic [MANTISSA_BITS-1:0] mant_x10;

  assign is_space = (char_i == CH_SPACE) || (char_i >= CH_TAB && char_i <= CH_CR);
  assign is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);

  // Times ten as a shift-add, plus the digit value; wraps modulo the width.
  assign mant_x10 = (mant_q << 3) + (mant_q << 1)
                  + MANTISSA_BITS'(char_i - CH_ZERO);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    frac_d  = frac_q;
    seen_d  = seen_q;
    mant_d  = mant_q;
    count_d = count_q;
    err_d   = err_q;
    do_body = 1'b0;

    if (step_i && eos_i) begin
      // End of string: the result stage has taken the state, start afresh.
      phase_d = PH_LEAD;
      neg_d   = 1'b0;
      frac_d  = 1'b0;
      seen_d  = 1'b0;
      mant_d  = '0;
      count_d = '0;
      err_d   = ST_OK;
    end else if (step_i) begin
      case (phase_q)
        PH_LEAD: begin
          if (char_i == CH_NUL) begin
            err_d   = ST_EMPTY;
            phase_d = PH_DONE;
          end else if (is_space) begin
            phase_d = PH_LEAD;
          end else if (char_i == CH_MINUS) begin
            neg_d   = 1'b1;
            phase_d = PH_BODY;
          end else if (char_i == CH_PLUS) begin
            phase_d = PH_BODY;
          end else begin
            phase_d = PH_BODY;
            do_body = 1'b1;
          end
        end
        PH_BODY: begin
          do_body = 1'b1;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase

      if (do_body) begin
        if (char_i == CH_NUL) begin
          phase_d = PH_DONE;
        end else if (char_i == CH_POINT) begin
          if (frac_q) begin
            err_d   = ST_POINTS;
            phase_d = PH_DONE;
          end else begin
            frac_d = 1'b1;
          end
        end else if (is_digit) begin
          seen_d = 1'b1;
          mant_d = mant_x10;
          if (frac_q && count_q != SCALE_MAX) begin
            count_d = count_q + SCALE_W'(1);
          end
        end else if (!is_space) begin
          err_d   = ST_INVALID;
          phase_d = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      neg_q   <= 1'b0;
      frac_q  <= 1'b0;
      seen_q  <= 1'b0;
      mant_q  <= '0;
      count_q <= '0;
      err_q   <= ST_OK;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      frac_q  <= frac_d;
      seen_q  <= seen_d;
      mant_q  <= mant_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  assign summary_o.lead       = (phase_q == PH_LEAD);
  assign summary_o.negative   = neg_q;
  assign summary_o.seen_digit = seen_q;
  assign summary_o.err        = err_q;
  assign summary_o.frac_count = count_q;
  assign mant_o               = mant_q;

  // A latched error always stops the parse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_OK) |-> (phase_q == PH_DONE))
    else $error("error latched while parse still running");

  // Fraction digits can only be counted after a decimal point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (frac_q && seen_q))
    else $error("fraction count without point or digit");

  // Any digit or sign takes the parser out of the leading whitespace.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEAD) |-> (!seen_q && !neg_q && !frac_q && mant_q == '0))
    else $error("parse state set during leading whitespace");

  // An end item always returns the parser to its initial state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && eos_i) |=> (phase_q == PH_LEAD && err_q == ST_OK && count_q == '0))
    else $error("parser not cleared after end of string");

endmodule

/* hw/rtl/dsp_result.sv */
module dsp_result import dsp_pkg::*; #(
  parameter int MANTISSA_BITS = MANTISSA_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  dsp_summary_t             summary_i,
  input  logic [MANTISSA_BITS-1:0] mant_i,
  input  logic                     m_ready_i,
  output logic                     m_valid_o,
  output logic [OUT_MANT_W-1:0]    m_mant_o,
  output logic [SCALE_W-1:0]       m_scale_o,
  output status_t                  m_status_o,
  output logic                     free_o
);

  logic                     valid_q, valid_d;
  logic [OUT_MANT_W-1:0]    mant_q, mant_d;
  logic [SCALE_W-1:0]       scale_q, scale_d;
  status_t                  status_q, status_d;
  logic [MANTISSA_BITS-1:0] signed_val;

  assign free_o = !valid_q || m_ready_i;

  assign signed_val = summary_i.negative ? (~mant_i + MANTISSA_BITS'(1)) : mant_i;

  always_comb begin
    status_d = summary_i.err;
    if (summary_i.err == ST_OK) begin
      if (summary_i.lead) begin
        status_d = ST_EMPTY;
      end else if (!summary_i.seen_digit) begin
        status_d = ST_NO_DIGITS;
      end
    end
    if (status_d == ST_OK) begin
      mant_d  = OUT_MANT_W'($signed(signed_val));
      scale_d = summary_i.frac_count;
    end else begin
      mant_d  = '0;
      scale_d = '0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mant_q   <= mant_d;
      scale_q  <= scale_d;
      status_q <= status_d;
    end
  end

  assign m_valid_o  = valid_q;
  assign m_mant_o   = mant_q;
  assign m_scale_o  = scale_q;
  assign m_status_o = status_q;

endmodule
